[hdl/dnv_pkg.sv]
package dnv_pkg;

  // Final status codes
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_LENGTH = 3'd2,
    ST_LABEL  = 3'd3,
    ST_CHAR   = 3'd4,
    ST_HYPHEN = 3'd5
  } status_t;

  localparam int unsigned LabelCntW = 7;
  localparam int unsigned NameCntW  = 9;

  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChHyphen = 8'h2d;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5a;
  localparam logic [7:0] ChLoA    = 8'h61;
  localparam logic [7:0] ChLoZ    = 8'h7a;
  localparam logic [7:0] Ch0      = 8'h30;
  localparam logic [7:0] Ch9      = 8'h39;
  localparam logic [7:0] CaseBit  = 8'h20;

  // One result as held in the output and skid registers
  typedef struct packed {
    logic       emit_dot;
    logic       emit_char;
    logic [7:0] ch;
    logic       done;
    status_t    status;
  } result_t;

endpackage

[hdl/domain_name_validator.sv]
// Channel  | handshake             | payload
// ---------+-----------------------+--------------------------------------------
// input    | in_valid / in_ready   | in_char[7:0], in_char_present, in_last
// result   | out_valid / out_ready | out_emit_dot, out_emit_char, out_char[7:0],
//          |                       | out_done_res, out_status[2:0]
//
// One item per cycle sustained while out_ready is high; each accepted item's
// result is registered, in the output or the skid register. All checks are a
// single pass of shallow compare/add logic from the accepted item and the scan
// state to the result. A skid register lets one more item in while a result
// waits; in_ready drops only while the skid register is full. Synchronous
// active-low reset clears the scan state and both result slots' valid flags.
module domain_name_validator import dnv_pkg::*; #(
  parameter int unsigned MAX_NAME_LEN  = 253,  // 1..510
  parameter int unsigned MAX_LABEL_LEN = 63    // 1..126
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_char_present,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_emit_dot,
  output logic       out_emit_char,
  output logic [7:0] out_char,
  output logic       out_done_res,
  output logic [2:0] out_status
);

  localparam logic [NameCntW-1:0]  NameLimit  = NameCntW'(MAX_NAME_LEN);
  localparam logic [LabelCntW-1:0] LabelLimit = LabelCntW'(MAX_LABEL_LEN);
  localparam logic [NameCntW-1:0]  NameSat    = '1;
  localparam logic [LabelCntW-1:0] LabelSat   = '1;

  // scan state
  logic [LabelCntW-1:0] label_cnt_r, label_cnt_nxt;
  logic [NameCntW-1:0]  name_cnt_r,  name_cnt_nxt;
  logic [NameCntW-1:0]  held_dots_r, held_dots_nxt;
  logic                 prev_hyph_r, prev_hyph_nxt;
  status_t              fault_r,     fault_nxt;
  logic                 saw_r,       saw_nxt;

  // output + skid slots
  result_t out_r, out_nxt, skid_r, skid_nxt;
  logic    out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt;

  result_t res;
  logic    in_xfer, out_xfer;

  // per-item decode
  logic                 is_dot, is_up, is_lo, is_dig, is_hyph, char_ok;
  logic                 has_dots, prev_label_bad, dot_fault;
  logic [LabelCntW-1:0] label_base, label_upd;
  logic [NameCntW:0]    name_sum;
  logic [NameCntW:0]    held_sum;
  logic                 end_label_bad;

  assign in_ready = !skid_vld_r;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_vld_r && out_ready;

  always_comb begin
    is_dot  = (in_char == ChDot);
    is_up   = (in_char >= ChUpA) && (in_char <= ChUpZ);
    is_lo   = (in_char >= ChLoA) && (in_char <= ChLoZ);
    is_dig  = (in_char >= Ch0) && (in_char <= Ch9);
    is_hyph = (in_char == ChHyphen);
    char_ok = is_up || is_lo || is_dig || is_hyph;

    has_dots       = (held_dots_r != '0);
    prev_label_bad = (label_cnt_r == '0) || (label_cnt_r > LabelLimit) || prev_hyph_r;
    // several held dots form an empty label
    dot_fault      = has_dots && (prev_label_bad || (held_dots_r > NameCntW'(1)));
    label_base     = has_dots ? '0 : label_cnt_r;
    label_upd      = (label_base == LabelSat) ? LabelSat : label_base + LabelCntW'(1);
    // held_dots + 1 + name, saturating; one top clamp covers both stages
    name_sum       = {1'b0, name_cnt_r} + {1'b0, held_dots_r} + (NameCntW+1)'(1);
    held_sum       = {1'b0, held_dots_r} + (NameCntW+1)'(1);

    label_cnt_nxt = label_cnt_r;
    name_cnt_nxt  = name_cnt_r;
    held_dots_nxt = held_dots_r;
    prev_hyph_nxt = prev_hyph_r;
    fault_nxt     = fault_r;
    saw_nxt       = saw_r;

    res        = '0;
    res.status = ST_OK;

    if (in_char_present) begin
      saw_nxt = 1'b1;
      if (is_dot) begin
        held_dots_nxt = held_sum[NameCntW] ? NameSat : held_sum[NameCntW-1:0];
      end else begin
        // first fault in byte order wins
        if (fault_r == ST_OK) begin
          if (dot_fault) begin
            fault_nxt = ST_LABEL;
          end else if (!char_ok) begin
            fault_nxt = ST_CHAR;
          end else if (is_hyph && (label_base == '0)) begin
            fault_nxt = ST_HYPHEN;
          end
        end
        name_cnt_nxt  = name_sum[NameCntW] ? NameSat : name_sum[NameCntW-1:0];
        held_dots_nxt = '0;
        label_cnt_nxt = label_upd;
        prev_hyph_nxt = is_hyph;
        res.emit_dot  = has_dots;
        res.emit_char = 1'b1;
        res.ch        = is_up ? (in_char | CaseBit) : in_char;
      end
    end

    end_label_bad = (label_cnt_nxt == '0) || (label_cnt_nxt > LabelLimit) || prev_hyph_nxt;

    if (in_last) begin
      res.done = 1'b1;
      if (!saw_nxt) begin
        res.status = ST_EMPTY;
      end else if ((name_cnt_nxt == '0) || (name_cnt_nxt > NameLimit)) begin
        res.status = ST_LENGTH;
      end else if (fault_nxt != ST_OK) begin
        res.status = fault_nxt;
      end else if (end_label_bad) begin
        res.status = ST_LABEL;
      end else begin
        res.status = ST_OK;
      end
      // fresh scan for the next name
      label_cnt_nxt = '0;
      name_cnt_nxt  = '0;
      held_dots_nxt = '0;
      prev_hyph_nxt = 1'b0;
      fault_nxt     = ST_OK;
      saw_nxt       = 1'b0;
    end
  end

  // output register with skid slot behind it
  always_comb begin
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r;
    skid_nxt     = skid_r;
    skid_vld_nxt = skid_vld_r;

    if (out_xfer || !out_vld_r) begin
      if (skid_vld_r) begin
        out_nxt      = skid_r;
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;
        if (in_xfer) begin
          skid_nxt     = res;
          skid_vld_nxt = 1'b1;
        end
      end else begin
        out_nxt     = res;
        out_vld_nxt = in_xfer;
      end
    end else if (in_xfer) begin
      skid_nxt     = res;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_cnt_r <= '0;
      name_cnt_r  <= '0;
      held_dots_r <= '0;
      prev_hyph_r <= 1'b0;
      fault_r     <= ST_OK;
      saw_r       <= 1'b0;
      out_vld_r   <= 1'b0;
      skid_vld_r  <= 1'b0;
    end else begin
      if (in_xfer) begin
        label_cnt_r <= label_cnt_nxt;
        name_cnt_r  <= name_cnt_nxt;
        held_dots_r <= held_dots_nxt;
        prev_hyph_r <= prev_hyph_nxt;
        fault_r     <= fault_nxt;
        saw_r       <= saw_nxt;
      end
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_emit_dot  = out_r.emit_dot;
  assign out_emit_char = out_r.emit_char;
  assign out_char      = out_r.ch;
  assign out_done_res  = out_r.done;
  assign out_status    = out_r.status;

endmodule
